FILE: hw/rtl/dker_pkg.sv
// ----------------------------------------------------------------------------
// dker_pkg
// Shared types and constants of the escape-key run-length decoder.
// ----------------------------------------------------------------------------
package dker_pkg;

   // Output lanes: the result carries four byte fields, so a group holds at
   // most four bytes whatever the lane count.
   localparam int LANES       = 4;
   localparam int GROUP_BYTES = (LANES < 4) ? LANES : 4;

   // Command queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int VCNT_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 40;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_KEY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECONDARY_KEY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECONDARY_EN  = 2'd2;

   // One expansion command: emit count copies of value
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] count;
   } cmd_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: hw/rtl/dker_front.sv
// ----------------------------------------------------------------------------
// dker_front
// Parses the compressed byte stream and issues expansion commands.
// ----------------------------------------------------------------------------
module dker_front
   import dker_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  q_status_type         q_status,
   output logic                 push,
   output cmd_type              push_cmd
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_COUNT = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_SKIP  = 2'd3;

   logic [BYTE_W-1:0] prim_key_ff, prim_key_in;
   logic [BYTE_W-1:0] sec_key_ff, sec_key_in;
   logic              sec_en_ff, sec_en_in;
   logic [1:0]        phase_ff, phase_in;
   logic              key_sel_ff, key_sel_in;
   logic [BYTE_W-1:0] run_count_ff, run_count_in;
   logic [BYTE_W-1:0] esc_key_ff, esc_key_in;
   logic              accept;

   // Take a byte whenever the queue has room for a command
   assign req_tready = ~q_status.full;
   assign accept     = req_tvalid & req_tready;

   // Configuration writes
   always_comb begin
      prim_key_in = prim_key_ff;
      sec_key_in  = sec_key_ff;
      sec_en_in   = sec_en_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRIMARY_KEY:   prim_key_in = csr_wdata;
            CSR_SECONDARY_KEY: sec_key_in  = csr_wdata;
            CSR_SECONDARY_EN:  sec_en_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Escape parser: one byte per cycle while the queue has room, at most one command per byte
   always_comb begin
      phase_in     = phase_ff;
      key_sel_in   = key_sel_ff;
      run_count_in = run_count_ff;
      esc_key_in   = esc_key_ff;
      push         = 1'b0;
      push_cmd     = '{value: req_tdata, count: 8'd1};
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_tdata == prim_key_ff) begin
                  esc_key_in = req_tdata;
                  key_sel_in = 1'b0;
                  phase_in   = PH_COUNT;
               end else if (sec_en_ff && req_tdata == sec_key_ff) begin
                  esc_key_in = req_tdata;
                  key_sel_in = 1'b1;
                  phase_in   = PH_COUNT;
               end else begin
                  push = 1'b1;
               end
            end
            PH_COUNT: begin
               if (req_tdata == '0) begin
                  push           = 1'b1;
                  push_cmd.value = esc_key_ff;
                  phase_in       = PH_IDLE;
               end else begin
                  run_count_in = req_tdata;
                  phase_in     = PH_VALUE;
               end
            end
            PH_VALUE: begin
               push           = 1'b1;
               push_cmd.count = run_count_ff;
               phase_in       = key_sel_ff ? PH_SKIP : PH_IDLE;
            end
            default: begin
               // drop the trailing byte of a secondary-key run
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_key_ff  <= '0;
         sec_key_ff   <= '0;
         sec_en_ff    <= 1'b0;
         phase_ff     <= PH_IDLE;
         key_sel_ff   <= 1'b0;
         run_count_ff <= '0;
         esc_key_ff   <= '0;
      end else begin
         prim_key_ff  <= prim_key_in;
         sec_key_ff   <= sec_key_in;
         sec_en_ff    <= sec_en_in;
         phase_ff     <= phase_in;
         key_sel_ff   <= key_sel_in;
         run_count_ff <= run_count_in;
         esc_key_ff   <= esc_key_in;
      end
   end

endmodule

FILE: hw/rtl/dker_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dker_cmd_fifo
// Short command queue that decouples the parser from the expander.
// ----------------------------------------------------------------------------
module dker_cmd_fifo
   import dker_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign q_status.full  = (fill_ff == QCNT_W'(QDEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign head_cmd       = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store commands; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("command queue read while empty");

endmodule

FILE: hw/rtl/dker_back.sv
// ----------------------------------------------------------------------------
// dker_back
// Expands commands into groups of up to four bytes behind an output register.
// ----------------------------------------------------------------------------
module dker_back
   import dker_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  q_status_type          q_status,
   input  cmd_type               head_cmd,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                 cur_valid_ff, cur_valid_in;
   logic [BYTE_W-1:0]    remain_ff, remain_in;
   logic [BYTE_W-1:0]    value_ff, value_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    lane_ff [4];
   logic [BYTE_W-1:0]    lane_in [4];
   logic [VCNT_W-1:0]    vcnt_ff, vcnt_in;
   logic                 last_ff, last_in;
   logic                 adv;
   logic                 fin;
   logic [VCNT_W-1:0]    take;

   // Group size and end of the current command
   assign take = (remain_ff >= BYTE_W'(GROUP_BYTES)) ? VCNT_W'(GROUP_BYTES)
                                                      : remain_ff[VCNT_W-1:0];
   assign fin  = (remain_ff <= BYTE_W'(GROUP_BYTES));
   assign adv  = cur_valid_ff & (~out_valid_ff | rsp_tready);
   assign pop  = ~q_status.empty & (~cur_valid_ff | (adv & fin));

   // Fill lanes below the group size, zero the rest
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         lane_in[j] = (VCNT_W'(j) < take) ? value_ff : '0;
      end
      vcnt_in = take;
      last_in = fin;
   end

   // Current command and output register
   always_comb begin
      cur_valid_in = cur_valid_ff;
      remain_in    = remain_ff;
      value_in     = value_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         remain_in    = head_cmd.count;
         value_in     = head_cmd.value;
      end else if (adv) begin
         remain_in = remain_ff - BYTE_W'(take);
         if (fin) begin
            cur_valid_in = 1'b0;
         end
      end
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      value_ff  <= value_in;
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            lane_ff[j] <= lane_in[j];
         end
         vcnt_ff <= vcnt_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 4 * BYTE_W - VCNT_W){1'b0}}, vcnt_ff,
                        lane_ff[3], lane_ff[2], lane_ff[1], lane_ff[0]};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (vcnt_ff != '0 && vcnt_ff <= VCNT_W'(GROUP_BYTES)))
      else $error("group byte count out of range");

   a_live_cmd: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> remain_ff != '0)
      else $error("active command with nothing left to emit");

   a_top_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && vcnt_ff != VCNT_W'(4)) |-> lane_ff[3] == '0)
      else $error("unused lane not cleared");

endmodule

FILE: hw/rtl/dual_key_escape_rle_decoder.sv
// ----------------------------------------------------------------------------
// dual_key_escape_rle_decoder
// Escape-key run-length decoder with a primary and an optional secondary key.
// ----------------------------------------------------------------------------
// A literal byte passes through the command queue, the current-command
//   register and the output register before rsp_tvalid rises for it.
// Throughput: one input byte per cycle while the four-entry command queue has
//   room; a run leaves in groups of up to four bytes, set by the four-lane
//   output register, and a full queue holds req_tready low.
// Reset: synchronous; clears keys, enable, parser state, queue and expander.
module dual_key_escape_rle_decoder
   import dker_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
   // [34:32] valid_count, [39:35] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   cmd_type      push_cmd;
   cmd_type      head_cmd;

   dker_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   dker_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   dker_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: test/dual_key_escape_rle_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_key_escape_rle_decoder_tb
// Self-checking bench for the escape-key run-length decoder. A directed table
// covers the keys, key-as-literal escapes, long runs, secondary-key trailing
// bytes and register corner cases. Random key/run/literal streams follow
// under three throttling regimes. Every output group is compared against an
// in-bench decoder model.
// ----------------------------------------------------------------------------
module dual_key_escape_rle_decoder_tb
   import dker_pkg::*;
();

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 250;
   localparam int RANDOM_ITEMS  = 310;
   localparam int N_ROWS        = 33;

   // Index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {DEC_IDLE, DEC_COUNT, DEC_VALUE, DEC_SKIP} dec_phase_type;
   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One output group as it leaves the block
   typedef struct packed {
      logic [3:0][BYTE_W-1:0] lanes;
      logic [VCNT_W-1:0]      count;
      logic                   last;
   } group_type;

   // Directed row: a byte transfer or a register write; typed rows carry a
   // single-byte group that is expected verbatim
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [BYTE_W-1:0]     value;
      logic                  typed;
      logic [BYTE_W-1:0]     literal;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [BYTE_W-1:0]     csr_wdata  = '0;

   // Decoder model state and register mirror
   dec_phase_type     dec_phase     = DEC_IDLE;
   logic              sel_secondary = 1'b0;
   logic [BYTE_W-1:0] pending_count = '0;
   logic [BYTE_W-1:0] latched_key   = '0;
   logic [BYTE_W-1:0] cfg_primary   = '0;
   logic [BYTE_W-1:0] cfg_secondary = '0;
   logic              cfg_enable    = 1'b0;

   group_type expected_groups[$];
   int     fail_count    = 0;
   int     items_sent    = 0;
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     stall_cycles  = 0;
   int     hold_left     = 0;
   bit     pressure_on   = 1'b0;
   bit     hold_done     = 1'b0;

   stim_row_type dir_rows [N_ROWS] = '{
      // literal right after reset, then key 0x00 escapes with default keys
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h55, 1'b1, 8'h55},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b1, 8'h00},
      // longest run: 255 copies, 64 groups
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h5A, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SECONDARY_KEY, 8'h80, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_SECONDARY_EN,  8'h01, 1'b0, 8'h00},
      // secondary run with its trailing ignored byte
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h80, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h03, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h11, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hC3, 1'b0, 8'h00},
      // both keys as literals
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b1, 8'hFF},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h80, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b1, 8'h80},
      // run value equal to a key, trailing byte equal to a key
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h80, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h04, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h80, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      // write to an unused index changes nothing
      '{ROW_CSR,  CSR_UNUSED,        8'h42, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h42, 1'b1, 8'h42},
      // equal keys: primary wins, so no trailing byte
      '{ROW_CSR,  CSR_SECONDARY_KEY, 8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h02, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h44, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h99, 1'b1, 8'h99},
      // key change in the middle of an escape keeps the latched key
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b0, 8'h00},
      '{ROW_CSR,  CSR_PRIMARY_KEY,   8'h12, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'h00, 1'b1, 8'hFF},
      // secondary disabled: its key passes as a literal
      '{ROW_CSR,  CSR_SECONDARY_EN,  8'h00, 1'b0, 8'h00},
      '{ROW_BYTE, CSR_PRIMARY_KEY,   8'hFF, 1'b1, 8'hFF}
   };

   dual_key_escape_rle_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
      // [34:32] valid_count, [39:35] zero
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),   // last_of_run
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Split n copies of a byte into groups of up to GROUP_BYTES lanes
   function automatic void add_copies(input logic [BYTE_W-1:0] value, input int n,
                                      ref group_type groups[$]);
      group_type g;
      int        left;
      int        take;
      left = n;
      while (left > 0) begin
         take    = (left < GROUP_BYTES) ? left : GROUP_BYTES;
         g.lanes = '0;
         for (int j = 0; j < take; j++) g.lanes[j] = value;
         g.count = take[VCNT_W-1:0];
         left    = left - take;
         g.last  = (left == 0);
         groups.push_back(g);
      end
   endfunction

   // Advance the decoder model by one input byte and collect its groups
   function automatic void predict_decode(input logic [BYTE_W-1:0] b,
                                          ref group_type groups[$]);
      case (dec_phase)
         DEC_IDLE: begin
            if (b == cfg_primary) begin
               latched_key   = b;
               sel_secondary = 1'b0;
               dec_phase     = DEC_COUNT;
            end else if (cfg_enable && b == cfg_secondary) begin
               latched_key   = b;
               sel_secondary = 1'b1;
               dec_phase     = DEC_COUNT;
            end else begin
               add_copies(b, 1, groups);
            end
         end
         DEC_COUNT: begin
            if (b == 8'h00) begin
               dec_phase = DEC_IDLE;
               add_copies(latched_key, 1, groups);
            end else begin
               pending_count = b;
               dec_phase     = DEC_VALUE;
            end
         end
         DEC_VALUE: begin
            dec_phase = sel_secondary ? DEC_SKIP : DEC_IDLE;
            add_copies(b, int'(pending_count), groups);
         end
         default: begin
            dec_phase = DEC_IDLE;
         end
      endcase
   endfunction

   // Offer one byte, hold it until the transfer, then queue its groups
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input logic [BYTE_W-1:0] literal);
      group_type groups[$];
      group_type g;
      logic      accepted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_tready;
      end
      predict_decode(b, groups);
      if (typed) begin
         g.lanes    = '0;
         g.lanes[0] = literal;
         g.count    = 3'd1;
         g.last     = 1'b1;
         expected_groups.push_back(g);
      end else begin
         foreach (groups[k]) expected_groups.push_back(groups[k]);
      end
   endtask

   // Drop valid, drain every expected group, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_groups.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PRIMARY_KEY:   cfg_primary   = value;
         CSR_SECONDARY_KEY: cfg_secondary = value;
         CSR_SECONDARY_EN:  cfg_enable    = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One random sequence: mostly well-formed runs, key literals and plain
   // literals; a stray byte finishes any escape left open by noise
   task automatic send_random_sequence();
      int                pick;
      int                n;
      logic              via_secondary;
      logic [BYTE_W-1:0] key;
      logic [BYTE_W-1:0] b;
      pick          = $urandom_range(0, 99);
      via_secondary = cfg_enable && (cfg_secondary != cfg_primary) &&
                      ($urandom_range(0, 1) == 1);
      key           = via_secondary ? cfg_secondary : cfg_primary;
      if (dec_phase != DEC_IDLE || pick >= 90) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 8'h00);
         items_sent += 1;
      end else if (pick < 45) begin
         n = $urandom_range(0, 99);
         if (n < 85)      n = $urandom_range(1, 12);
         else if (n < 96) n = $urandom_range(13, 64);
         else             n = $urandom_range(200, 255);
         send_byte(key, 1'b0, 8'h00);
         send_byte(n[BYTE_W-1:0], 1'b0, 8'h00);
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 8'h00);
         items_sent += 3;
         if (via_secondary) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 8'h00);
            items_sent += 1;
         end
      end else if (pick < 60) begin
         send_byte(key, 1'b0, 8'h00);
         send_byte(8'h00, 1'b0, 8'h00);
         items_sent += 2;
      end else begin
         do b = BYTE_W'($urandom_range(0, 255));
         while (b == cfg_primary || (cfg_enable && b == cfg_secondary));
         send_byte(b, 1'b0, 8'h00);
         items_sent += 1;
      end
   endtask

   // Compare one output transfer with the oldest expected group
   task automatic check_group();
      group_type g;
      if (expected_groups.size() == 0) begin
         $error("unexpected output group: tdata %0h tlast %0b", rsp_tdata, rsp_tlast);
         fail_count++;
      end else begin
         g = expected_groups.pop_front();
         for (int i = 0; i < 4; i++) begin
            if (rsp_tdata[8*i +: 8] !== g.lanes[i]) begin
               $error("out_byte%0d expected %0h actual %0h", i, g.lanes[i], rsp_tdata[8*i +: 8]);
               fail_count++;
            end
         end
         if (rsp_tdata[34:32] !== g.count) begin
            $error("valid_count expected %0d actual %0d", g.count, rsp_tdata[34:32]);
            fail_count++;
         end
         if (rsp_tlast !== g.last) begin
            $error("last_of_run expected %0b actual %0b", g.last, rsp_tlast);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_group();
   end

   // Receiver throttle; one long hold-off once pressure is requested
   always @(negedge clock) begin
      if (pressure_on && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Stop the run when no transfer happens on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int ph;
      int target;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      send_idle_pct = 18;
      recv_idle_pct = 51;
      for (int r = 0; r < N_ROWS; r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            settle();
            write_csr(dir_rows[r].index, dir_rows[r].value);
         end else begin
            send_byte(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].literal);
         end
      end

      // Random streams under three throttling regimes and key settings
      for (ph = 0; ph < 3; ph++) begin
         settle();
         case (ph)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 51;
               write_csr(CSR_PRIMARY_KEY, 8'hFF);
               write_csr(CSR_SECONDARY_KEY, BYTE_W'($urandom_range(0, 255)));
               write_csr(CSR_SECONDARY_EN, 8'h01);
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 18;
               write_csr(CSR_PRIMARY_KEY, BYTE_W'($urandom_range(0, 255)));
               write_csr(CSR_SECONDARY_KEY, 8'h00);
               write_csr(CSR_SECONDARY_EN, 8'hFF);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_csr(CSR_PRIMARY_KEY, 8'h00);
               write_csr(CSR_SECONDARY_KEY, 8'hFF);
               write_csr(CSR_SECONDARY_EN, BYTE_W'($urandom_range(0, 255)));
               pressure_on = 1'b1;
            end
         endcase
         target = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < target) send_random_sequence();
      end

      // Drain and report
      settle();
      if (expected_groups.size() != 0) begin
         $error("%0d expected groups never arrived", expected_groups.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
